### design/keyed_lifo_stack_unit_defines.svh
// Assertion macros for the keyed LIFO stack unit.
// Used by the sequencer; expects clk_i and rst_ni in the including module.
`ifndef KEYED_LIFO_STACK_UNIT_DEFINES_SVH
`define KEYED_LIFO_STACK_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/kls_pkg.sv
// Shared types and constants for the keyed LIFO stack unit.
// No dependencies.
`default_nettype none

package kls_pkg;

  localparam int DEPTH_DEF    = 8;
  localparam int KEY_BITS_DEF = 32;

  localparam int OP_W      = 3;
  localparam int CAR_KEY_W = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 3;
  localparam int OCC_W     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_TOP,
    ST_SCAN_UP,
    ST_SCAN_DN,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    status_e              status;
    logic [CAR_KEY_W-1:0] key_out;
    logic [POS_W-1:0]     position;
    logic [OCC_W-1:0]     occupancy;
  } res_t;

endpackage

`default_nettype wire

### design/kls_store.sv
// Entry store of the keyed LIFO stack: one write port, one registered read port.
// Depends on kls_pkg.
`default_nettype none

module kls_store
  import kls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire mem_ctl_t            ctl_i,
  input  wire logic [IW-1:0]       wr_addr_i,
  input  wire logic [KEY_BITS-1:0] wr_data_i,
  input  wire logic [IW-1:0]       rd_addr_i,
  output logic      [KEY_BITS-1:0] rd_data_o
);

  logic [KEY_BITS-1:0] mem_q [DEPTH];
  logic [KEY_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### design/kls_seq.sv
// Sequencer of the keyed LIFO stack: walks the store one entry per cycle
// through a single key comparator. Depends on kls_pkg and the defines header.
`default_nettype none
`include "keyed_lifo_stack_unit_defines.svh"

module kls_seq
  import kls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FW      = $clog2(DEPTH + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [CAR_KEY_W-1:0] car_key_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output res_t                      res_o,
  output mem_ctl_t                  mem_ctl_o,
  output logic      [IW-1:0]        wr_addr_o,
  output logic      [KEY_BITS-1:0]  wr_data_o,
  output logic      [IW-1:0]        rd_addr_o,
  input  wire logic [KEY_BITS-1:0]  rd_data_i
);

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [IW-1:0]        idx_q, idx_d;
  status_e              status_q, status_d;
  logic [CAR_KEY_W-1:0] kout_q, kout_d;
  logic [POS_W-1:0]     pos_q, pos_d;

  logic hit;
  logic at_top;
  logic shift_last;

  // The single comparator every scan step goes through.
  assign hit        = (rd_data_i == key_q);
  assign at_top     = ((FW'(idx_q) + FW'(1)) == fill_q);
  assign shift_last = ((FW'(idx_q) + FW'(2)) == fill_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (op_q)
          OP_POP, OP_PEEK: state_d = (fill_q == '0) ? ST_DONE : ST_RD_TOP;
          OP_SEARCH:       state_d = (fill_q == '0) ? ST_DONE : ST_SCAN_UP;
          OP_REMOVE:       state_d = (fill_q == '0) ? ST_DONE : ST_SCAN_DN;
          default:         state_d = ST_DONE;
        endcase
      end
      ST_RD_TOP: state_d = ST_DONE;
      ST_SCAN_UP: begin
        if (hit || at_top) state_d = ST_DONE;
      end
      ST_SCAN_DN: begin
        if (hit) begin
          state_d = at_top ? ST_DONE : ST_SHIFT;
        end else if (idx_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (shift_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    status_d  = status_q;
    kout_d    = kout_q;
    pos_d     = pos_q;
    mem_ctl_o = '0;
    wr_addr_o = idx_q;
    wr_data_o = key_q;
    rd_addr_o = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_e'(operation_i);
          key_d    = KEY_BITS'(car_key_i);
          status_d = STAT_OK;
          kout_d   = '0;
          pos_d    = '0;
        end
      end
      ST_DISPATCH: begin
        case (op_q)
          OP_PUSH: begin
            if (fill_q == FW'(DEPTH)) begin
              status_d = STAT_FULL;
            end else begin
              mem_ctl_o.wr_en = 1'b1;
              wr_addr_o       = IW'(fill_q);
              fill_d          = fill_q + FW'(1);
            end
          end
          OP_POP, OP_PEEK: begin
            if (fill_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              rd_addr_o       = IW'(fill_q - FW'(1));
            end
          end
          OP_SEARCH: begin
            if (fill_q == '0) begin
              status_d = STAT_NOTFOUND;
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              rd_addr_o       = '0;
              idx_d           = '0;
            end
          end
          OP_REMOVE: begin
            if (fill_q == '0) begin
              status_d = STAT_EMPTY;
            end else begin
              mem_ctl_o.rd_en = 1'b1;
              rd_addr_o       = IW'(fill_q - FW'(1));
              idx_d           = IW'(fill_q - FW'(1));
            end
          end
          default: ;
        endcase
      end
      ST_RD_TOP: begin
        kout_d = CAR_KEY_W'(rd_data_i);
        if (op_q == OP_POP) fill_d = fill_q - FW'(1);
      end
      ST_SCAN_UP: begin
        if (hit) begin
          pos_d = POS_W'(idx_q);
        end else if (at_top) begin
          status_d = STAT_NOTFOUND;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = IW'(idx_q + 1'b1);
          idx_d           = IW'(idx_q + 1'b1);
        end
      end
      ST_SCAN_DN: begin
        if (hit) begin
          if (at_top) begin
            fill_d = fill_q - FW'(1);
          end else begin
            // Fetch the entry above the match; it moves down next cycle.
            mem_ctl_o.rd_en = 1'b1;
            rd_addr_o       = IW'(idx_q + 1'b1);
          end
        end else if (idx_q == '0) begin
          status_d = STAT_NOTFOUND;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = IW'(idx_q - 1'b1);
          idx_d           = IW'(idx_q - 1'b1);
        end
      end
      ST_SHIFT: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = idx_q;
        wr_data_o       = rd_data_i;
        if (shift_last) begin
          fill_d = fill_q - FW'(1);
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = IW'(FW'(idx_q) + FW'(2));
          idx_d           = IW'(idx_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    kout_q   <= kout_d;
    pos_q    <= pos_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign res_valid_o     = (state_q == ST_DONE);
  assign res_o.status    = status_q;
  assign res_o.key_out   = kout_q;
  assign res_o.position  = pos_q;
  assign res_o.occupancy = OCC_W'(fill_q);

  `KLS_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FW'(DEPTH), "fill exceeds depth")
  `KLS_ASSERT_IMP(a_scan_in_range, (state_q == ST_SCAN_UP) || (state_q == ST_SCAN_DN) || (state_q == ST_SHIFT), FW'(idx_q) < fill_q, "scan index beyond fill")
  `KLS_ASSERT_NXT(a_idle_fill_stable, state_q == ST_IDLE, fill_q == $past(fill_q), "fill moved while idle")
  `KLS_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_DISPATCH, "accepted word not dispatched")

endmodule

`default_nettype wire

### design/keyed_lifo_stack_unit.sv
// Top level of the keyed LIFO stack unit: sequencer, entry store, output register.
// Depends on kls_pkg, kls_store and kls_seq.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | operation_i, car_key_i
//   out     | output    | out_valid_o/out_ready_i | status_o, key_out_o, position_o, occupancy_o
//
// One word is processed at a time; in_ready_o is high only when the sequencer is idle.
// Push, unused codes and requests on an empty stack go from dispatch straight to the result;
// pop and peek read the top entry; search scans up, remove scans down and shifts the rest down,
// limited by the single comparator and the one read port of the store, stepped one entry per cycle.
// Reset clears the fill count and control state; the entries need no clearing pass.
// A stalled output holds its word while the next request is taken and worked on.
`default_nettype none

module keyed_lifo_stack_unit
  import kls_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [CAR_KEY_W-1:0] car_key_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [STATUS_W-1:0]  status_o,
  output logic      [CAR_KEY_W-1:0] key_out_o,
  output logic      [POS_W-1:0]     position_o,
  output logic      [OCC_W-1:0]     occupancy_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_ctl_t            mem_ctl;
  logic [IW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [IW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_data;
  logic                res_valid;
  logic                res_ready;
  res_t                res;

  res_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  kls_seq #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .car_key_i   (car_key_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  kls_store #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // The output register takes a new word when it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign key_out_o   = out_q.key_out;
  assign position_o  = out_q.position;
  assign occupancy_o = out_q.occupancy;

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyed_lifo_stack_unit: a directed table, then random requests.
// Every result word is checked against its typed table row or an in-bench stack predictor. Depends on kls_pkg.
module tb;
  import kls_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RAND_ITEMS  = 700;
  localparam int DRAIN_CYC   = 4 * DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIR       = 25;

  // Codes five to seven are not operations; the unit must ignore them.
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [CAR_KEY_W-1:0] key;
    bit                   typed;
    res_t                 want;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i = '0;
  logic [CAR_KEY_W-1:0] car_key_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [CAR_KEY_W-1:0] key_out_o;
  logic [POS_W-1:0]     position_o;
  logic [OCC_W-1:0]     occupancy_o;

  // Predicted contents of the stack.
  logic [CAR_KEY_W-1:0] stack_mem [DEPTH_DEF];
  int                   stack_fill = 0;
  res_t                 pending_results [$];

  int send_idle_pct = 36;
  int recv_idle_pct = 61;
  int fail_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_notfound = 0;
  int n_ignored = 0;

  logic [CAR_KEY_W-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                         32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A};

  // Rows with a typed result are plain to read off; the rest go to the predictor.
  stim_row_t dir_rows [N_DIR] = '{
    '{OP_POP,    32'h0,         1'b1, '{STAT_EMPTY,    32'h0,         3'd0, 4'd0}},
    '{OP_PEEK,   32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY,    32'h0,         3'd0, 4'd0}},
    '{OP_SEARCH, 32'h0,         1'b1, '{STAT_NOTFOUND, 32'h0,         3'd0, 4'd0}},
    '{OP_REMOVE, 32'h0,         1'b1, '{STAT_EMPTY,    32'h0,         3'd0, 4'd0}},
    '{OP_PUSH,   32'h0,         1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd1}},
    '{OP_PUSH,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd2}},
    '{OP_PUSH,   32'hA5A5_A5A5, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd3}},
    '{OP_PUSH,   32'h0,         1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd4}},
    '{OP_PUSH,   32'h5A5A_5A5A, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd5}},
    '{OP_PUSH,   32'h0000_0001, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd6}},
    '{OP_PUSH,   32'h8000_0000, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd7}},
    '{OP_PUSH,   32'h7FFF_FFFF, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd8}},
    '{OP_PUSH,   32'h1234_5678, 1'b1, '{STAT_FULL,     32'h0,         3'd0, 4'd8}},
    '{OP_SEARCH, 32'h0,         1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd8}},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{STAT_OK,       32'h0,         3'd7, 4'd8}},
    '{OP_SEARCH, 32'h1234_5678, 1'b1, '{STAT_NOTFOUND, 32'h0,         3'd0, 4'd8}},
    '{OP_PEEK,   32'h0,         1'b1, '{STAT_OK,       32'h7FFF_FFFF, 3'd0, 4'd8}},
    '{OP_REMOVE, 32'h0,         1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd7}},
    '{OP_SEARCH, 32'h5A5A_5A5A, 1'b0, '0},
    '{OP_REMOVE, 32'hDEAD_BEEF, 1'b1, '{STAT_NOTFOUND, 32'h0,         3'd0, 4'd7}},
    '{OP_RSVD_5, 32'h0,         1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd7}},
    '{OP_RSVD_6, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd7}},
    '{OP_RSVD_7, 32'hFFFF_FFFF, 1'b1, '{STAT_OK,       32'h0,         3'd0, 4'd7}},
    '{OP_POP,    32'h0,         1'b1, '{STAT_OK,       32'h7FFF_FFFF, 3'd0, 4'd6}},
    '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0}
  };

  keyed_lifo_stack_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .car_key_i   (car_key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .key_out_o   (key_out_o),
    .position_o  (position_o),
    .occupancy_o (occupancy_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Applies one request to the predicted stack and returns the word it should produce.
  function automatic res_t stack_response(input logic [OP_W-1:0] op,
                                          input logic [CAR_KEY_W-1:0] key);
    res_t r;
    int   hit;
    r = '0;
    hit = -1;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          stack_mem[stack_fill] = key;
          stack_fill++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stack_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.key_out = stack_mem[stack_fill-1];
          if (op == OP_POP) stack_fill--;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < stack_fill; i++)
          if (hit < 0 && stack_mem[i] == key) hit = i;
        if (hit < 0) r.status = STAT_NOTFOUND;
        else r.position = hit[POS_W-1:0];
      end
      OP_REMOVE: begin
        if (stack_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // The topmost match goes; everything above it slides down one place.
          for (int i = stack_fill - 1; i >= 0; i--)
            if (hit < 0 && stack_mem[i] == key) hit = i;
          if (hit < 0) begin
            r.status = STAT_NOTFOUND;
          end else begin
            for (int i = hit; i < stack_fill - 1; i++) stack_mem[i] = stack_mem[i+1];
            stack_fill--;
          end
        end
      end
      default: ;
    endcase
    r.occupancy = stack_fill[OCC_W-1:0];
    return r;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows acceptance.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [CAR_KEY_W-1:0] key,
                           input bit typed, input res_t want);
    res_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    car_key_i   <= key;
    do @(posedge clk_i); while (!in_ready_o);
    got = stack_response(op, key);
    if (op > OP_REMOVE) n_ignored++;
    case (got.status)
      STAT_FULL:     n_full++;
      STAT_EMPTY:    n_empty++;
      STAT_NOTFOUND: n_notfound++;
      default: ;
    endcase
    pending_results.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [CAR_KEY_W-1:0] want,
                             input logic [CAR_KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request waiting for it");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("key_out", want.key_out, key_out_o);
        check_field("position", want.position, position_o);
        check_field("occupancy", want.occupancy, occupancy_o);
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]      op;
    logic [CAR_KEY_W-1:0] key;
    int                   roll;
    int                   push_pct;
    bit                   growing;
    growing = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
    // Hold the sender off until the unit has delivered everything.
    wait_drained();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS / 3) begin
        wait_drained();
        send_idle_pct = 61;
        recv_idle_pct = 36;
      end else if (n == 2 * RAND_ITEMS / 3) begin
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Drift between filling and draining so both full and empty come up often.
      if (stack_fill == DEPTH_DEF) growing = 1'b0;
      else if (stack_fill == 0) growing = 1'b1;
      else if ($urandom_range(0, 39) == 0) growing = !growing;
      push_pct = growing ? 55 : 12;

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
      end else if (roll < 3 + push_pct) begin
        op = OP_PUSH;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_POP;
          1:       op = OP_PEEK;
          2:       op = OP_SEARCH;
          default: op = OP_REMOVE;
        endcase
      end

      // Keys repeat often enough that search and remove find matches, duplicates included.
      roll = $urandom_range(0, 9);
      if (roll < 4 || (roll >= 7 && stack_fill == 0)) key = $urandom;
      else if (roll < 7) key = key_pool[$urandom_range(0, 5)];
      else key = stack_mem[$urandom_range(0, stack_fill - 1)];

      send_word(op, key, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("Ran %0d table rows and %0d random requests; %0d result words checked.",
             N_DIR, RAND_ITEMS, results_seen);
    $display("Outcomes seen: %0d full, %0d empty, %0d not found, %0d ignored codes.",
             n_full, n_empty, n_notfound, n_ignored);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/kls_pkg.sv
design/kls_store.sv
design/kls_seq.sv
design/keyed_lifo_stack_unit.sv
verif/tb.sv
